### rtl/core/olist_pkg.sv
// Shared types and codes for the ordered list engine.
package olist_pkg;

    typedef enum logic [2:0] {
        ACT_APPEND    = 3'd0,
        ACT_PREPEND   = 3'd1,
        ACT_INSERT    = 3'd2,
        ACT_DELETE    = 3'd3,
        ACT_DELETE_EQ = 3'd4,
        ACT_READ      = 3'd5
    } action_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_POS   = 2'd1,
        ST_FULL      = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SHIFT_UP,
        S_COMPACT,
        S_READ
    } state_t;

    localparam int IN_BITS  = 40;
    localparam int OUT_BITS = 48;

endpackage

### rtl/core/olist_ram.sv
// Generic single-write, single-read RAM with registered read data.
module olist_ram
    #(
        parameter int WIDTH = 32,
        parameter int DEPTH = 16
    )
    (
        input  logic                     clk,
        input  logic                     we,
        input  logic [$clog2(DEPTH)-1:0] waddr,
        input  logic [WIDTH-1:0]         wdata,
        input  logic                     re,
        input  logic [$clog2(DEPTH)-1:0] raddr,
        output logic [WIDTH-1:0]         rdata
    );

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### rtl/core/ordered_list_engine.sv
// Top level of the ordered list engine: request sequencer around the entry RAM.
//
//  port group  dir  fields (lowest bit first)
//  s_axis      in   action[2:0] item_value[34:3] position[39:35]
//  m_axis      out  read_value[31:0] entry_count[36:32] removed_count[41:37]
//                   status[43:42], zero pad to 48
//
// A read passes through S_READ; append, insert at the end, rejected and unused
// requests finish while idle. Insert at p moves entries up in S_SHIFT_UP, with
// one RAM read and write per moved entry. Delete at p and delete-all-equal (done
// while idle when empty) use the one-read/one-write RAM sweep in S_COMPACT.
// Reset clears count and control; RAM contents stay undefined (never read).
// A new item is taken when idle and the result register is empty or drains.
module ordered_list_engine
    import olist_pkg::*;
    #(
        parameter int CAPACITY   = 16,
        parameter int VALUE_BITS = 32
    )
    (
        input  logic                clk,
        input  logic                rst_n,
        input  logic                s_axis_tvalid,
        output logic                s_axis_tready,
        input  logic [IN_BITS-1:0]  s_axis_tdata,   // action, item_value, position
        output logic                m_axis_tvalid,
        input  logic                m_axis_tready,
        output logic [OUT_BITS-1:0] m_axis_tdata    // read_value, entry_count,
                                                    // removed_count, status
    );

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = (CW > 5) ? CW : 5;
    localparam int WB = (VALUE_BITS > 32) ? VALUE_BITS : 32;

    // input fields
    logic [2:0]         action;
    logic signed [31:0] item_value;
    logic [4:0]         position;
    assign action     = s_axis_tdata[2:0];
    assign item_value = s_axis_tdata[34:3];
    assign position   = s_axis_tdata[39:35];

    logic signed [WB-1:0]   in_wide;
    logic [VALUE_BITS-1:0]  in_val;
    assign in_wide = WB'(item_value);
    assign in_val  = in_wide[VALUE_BITS-1:0];

    state_t state_reg, state_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic [2:0]            act_reg, act_next;
    logic [VALUE_BITS-1:0] val_reg, val_next;
    logic [AW-1:0]         pos_reg, pos_next;
    logic [AW-1:0]         ridx_reg, ridx_next;
    logic [AW-1:0]         widx_reg, widx_next;
    logic [AW-1:0]         raddr_q_reg, raddr_q_next;
    logic                  iss_reg, iss_next;
    logic                  rpend_reg, rpend_next;
    logic [CW-1:0]         removed_reg, removed_next;

    logic                  out_valid_reg, out_valid_next;
    logic [31:0]           o_read_reg, o_read_next;
    logic [CW-1:0]         o_cnt_reg, o_cnt_next;
    logic [CW-1:0]         o_rem_reg, o_rem_next;
    status_t               o_st_reg, o_st_next;

    logic                  we, re;
    logic [AW-1:0]         waddr, raddr;
    logic [VALUE_BITS-1:0] wdata, rdata;

    logic                  accept;
    logic [PW-1:0]         pos_w, cnt_w;
    logic                  is_insert, full, finish, skip;
    logic [AW-1:0]         last_idx;

    assign s_axis_tready = (state_reg == S_IDLE) && (!out_valid_reg || m_axis_tready);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign pos_w         = PW'(position);
    assign cnt_w         = PW'(cnt_reg);
    assign is_insert     = (action == ACT_APPEND) || (action == ACT_PREPEND)
                           || (action == ACT_INSERT);
    assign full          = (cnt_reg == CW'(CAPACITY));
    assign last_idx      = AW'(cnt_reg - CW'(1));
    // compaction drops the addressed slot or every matching entry
    assign skip          = (act_reg == ACT_DELETE) ? (raddr_q_reg == pos_reg)
                                                   : (rdata == val_reg);

    olist_ram #(.WIDTH(VALUE_BITS), .DEPTH(CAPACITY)) u_ram
    (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (is_insert)
                    begin
                        if (!full && !((action == ACT_INSERT) && (pos_w > cnt_w)))
                        begin
                            if ((action == ACT_PREPEND && cnt_reg != '0)
                                || (action == ACT_INSERT && pos_w != cnt_w))
                            begin
                                state_next = S_SHIFT_UP;
                            end
                        end
                    end
                    else if (action == ACT_DELETE)
                    begin
                        if (pos_w < cnt_w)
                        begin
                            state_next = S_COMPACT;
                        end
                    end
                    else if (action == ACT_DELETE_EQ)
                    begin
                        if (cnt_reg != '0)
                        begin
                            state_next = S_COMPACT;
                        end
                    end
                    else if (action == ACT_READ)
                    begin
                        if (pos_w < cnt_w)
                        begin
                            state_next = S_READ;
                        end
                    end
                end
            end
            S_SHIFT_UP:
            begin
                if (!iss_reg && !rpend_reg)
                begin
                    state_next = S_IDLE;
                end
            end
            S_COMPACT:
            begin
                if (!iss_reg && !rpend_reg)
                begin
                    state_next = S_IDLE;
                end
            end
            S_READ:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // datapath and RAM control
    always_comb
    begin
        cnt_next     = cnt_reg;
        act_next     = act_reg;
        val_next     = val_reg;
        pos_next     = pos_reg;
        ridx_next    = ridx_reg;
        widx_next    = widx_reg;
        raddr_q_next = raddr_q_reg;
        iss_next     = iss_reg;
        rpend_next   = 1'b0;
        removed_next = removed_reg;
        we           = 1'b0;
        waddr        = '0;
        wdata        = rdata;
        re           = 1'b0;
        raddr        = '0;
        finish       = 1'b0;
        o_read_next  = '0;
        o_cnt_next   = cnt_reg;
        o_rem_next   = '0;
        o_st_next    = ST_OK;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    act_next     = action;
                    val_next     = in_val;
                    removed_next = '0;
                    iss_next     = 1'b1;
                    if (is_insert)
                    begin
                        if (full)
                        begin
                            finish    = 1'b1;
                            o_st_next = ST_FULL;
                        end
                        else if ((action == ACT_INSERT) && (pos_w > cnt_w))
                        begin
                            finish    = 1'b1;
                            o_st_next = ST_BAD_POS;
                        end
                        else
                        begin
                            if (action == ACT_APPEND)
                            begin
                                pos_next = AW'(cnt_reg);
                            end
                            else if (action == ACT_PREPEND)
                            begin
                                pos_next = '0;
                            end
                            else
                            begin
                                pos_next = AW'(position);
                            end
                            ridx_next = last_idx;
                            if (pos_next == AW'(cnt_reg))
                            begin
                                // nothing to move: write in place
                                we         = 1'b1;
                                waddr      = pos_next;
                                wdata      = in_val;
                                cnt_next   = cnt_reg + CW'(1);
                                finish     = 1'b1;
                                o_cnt_next = cnt_next;
                            end
                        end
                    end
                    else if (action == ACT_DELETE)
                    begin
                        pos_next  = AW'(position);
                        ridx_next = AW'(position);
                        widx_next = AW'(position);
                        if (pos_w >= cnt_w)
                        begin
                            finish    = 1'b1;
                            o_st_next = ST_BAD_POS;
                        end
                    end
                    else if (action == ACT_DELETE_EQ)
                    begin
                        ridx_next = '0;
                        widx_next = '0;
                        if (cnt_reg == '0)
                        begin
                            finish = 1'b1;
                        end
                    end
                    else if (action == ACT_READ)
                    begin
                        if (pos_w >= cnt_w)
                        begin
                            finish    = 1'b1;
                            o_st_next = ST_BAD_POS;
                        end
                        else
                        begin
                            re    = 1'b1;
                            raddr = AW'(position);
                        end
                    end
                    else
                    begin
                        finish = 1'b1;
                    end
                end
            end
            S_SHIFT_UP:
            begin
                // move entries up one slot from the top down, then drop the value in
                if (rpend_reg)
                begin
                    we    = 1'b1;
                    waddr = raddr_q_reg + AW'(1);
                    wdata = rdata;
                end
                else if (!iss_reg)
                begin
                    we         = 1'b1;
                    waddr      = pos_reg;
                    wdata      = val_reg;
                    cnt_next   = cnt_reg + CW'(1);
                    finish     = 1'b1;
                    o_cnt_next = cnt_next;
                end
                if (iss_reg)
                begin
                    re           = 1'b1;
                    raddr        = ridx_reg;
                    rpend_next   = 1'b1;
                    raddr_q_next = ridx_reg;
                    if (ridx_reg == pos_reg)
                    begin
                        iss_next = 1'b0;
                    end
                    else
                    begin
                        ridx_next = ridx_reg - AW'(1);
                    end
                end
            end
            S_COMPACT:
            begin
                // read ascending, write back survivors behind the read pointer
                if (rpend_reg)
                begin
                    if (skip)
                    begin
                        removed_next = removed_reg + CW'(1);
                    end
                    else
                    begin
                        we        = 1'b1;
                        waddr     = widx_reg;
                        wdata     = rdata;
                        widx_next = widx_reg + AW'(1);
                    end
                end
                if (iss_reg)
                begin
                    re           = 1'b1;
                    raddr        = ridx_reg;
                    rpend_next   = 1'b1;
                    raddr_q_next = ridx_reg;
                    if (ridx_reg == last_idx)
                    begin
                        iss_next = 1'b0;
                    end
                    else
                    begin
                        ridx_next = ridx_reg + AW'(1);
                    end
                end
                if (!iss_reg && !rpend_reg)
                begin
                    cnt_next   = cnt_reg - removed_reg;
                    finish     = 1'b1;
                    o_cnt_next = cnt_next;
                    o_rem_next = removed_reg;
                end
            end
            S_READ:
            begin
                finish      = 1'b1;
                o_read_next = 32'(signed'(rdata));
            end
            default:
            begin
            end
        endcase

        out_valid_next = out_valid_reg && !m_axis_tready;
        if (finish)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            o_read_next = o_read_reg;
            o_cnt_next  = o_cnt_reg;
            o_rem_next  = o_rem_reg;
            o_st_next   = o_st_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            iss_reg       <= 1'b0;
            rpend_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            iss_reg       <= iss_next;
            rpend_reg     <= rpend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg     <= act_next;
        val_reg     <= val_next;
        pos_reg     <= pos_next;
        ridx_reg    <= ridx_next;
        widx_reg    <= widx_next;
        raddr_q_reg <= raddr_q_next;
        removed_reg <= removed_next;
        o_read_reg  <= o_read_next;
        o_cnt_reg   <= o_cnt_next;
        o_rem_reg   <= o_rem_next;
        o_st_reg    <= o_st_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0, o_st_reg, 5'(o_rem_reg), 5'(o_cnt_reg), o_read_reg};

endmodule
